// ===== sv/bdq_pkg.sv =====
// bdq_pkg: shared constants, codes and types of the bounded deque
// no dependencies; compiled first

package bdq_pkg;

	localparam int unsigned DEPTH  = 8;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

	// request codes
	localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FUNC_PUSH_REAR  = 2'd1;
	localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
	localparam logic [1:0] FUNC_POP_REAR   = 2'd3;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} bdq_ctl_t;

endpackage

// ===== sv/bdq_req_if.sv =====
// bdq_req_if: request channel of the bounded deque (valid/ready + payload)
// depends on bdq_pkg

interface bdq_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          func;
	logic signed [bdq_pkg::DATA_W-1:0]   push_value;

	modport source (output valid, output func, output push_value, input ready);
	modport sink (input valid, input func, input push_value, output ready);
endinterface

// ===== sv/bdq_rsp_if.sv =====
// bdq_rsp_if: response channel of the bounded deque (valid/ready + payload)
// depends on bdq_pkg

interface bdq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [bdq_pkg::DATA_W-1:0]   pop_value;
	logic [1:0]                          status;
	logic [bdq_pkg::CNT_W-1:0]           occupancy;

	modport source (output valid, output pop_value, output status, output occupancy,
		input ready);
	modport sink (input valid, input pop_value, input status, input occupancy,
		output ready);
endinterface

// ===== sv/bdq_cell.sv =====
// bdq_cell: one slot of the deque cell row, shifts toward either neighbor
// depends on bdq_pkg

module bdq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdq_pkg::bdq_ctl_t                 ctl,
	input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
	input  logic signed [bdq_pkg::DATA_W-1:0] left_data,
	input  logic                              left_valid,
	input  logic signed [bdq_pkg::DATA_W-1:0] right_data,
	input  logic                              right_valid,
	output logic signed [bdq_pkg::DATA_W-1:0] data,
	output logic                              valid,
	output logic signed [bdq_pkg::DATA_W-1:0] tail_data
);

	logic signed [bdq_pkg::DATA_W-1:0] data_q;
	logic                              valid_q;
	logic                              is_tail;
	logic                              is_free_head;

	// last occupied cell, and first free cell behind the occupied run
	assign is_tail      = valid_q & ~right_valid;
	assign is_free_head = ~valid_q & left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_rear && is_free_head) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_rear && is_tail) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_rear && is_free_head) begin
			data_q <= push_value;
		end
	end

	assign data      = data_q;
	assign valid     = valid_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

// ===== sv/bounded_deque_unit.sv =====
// bounded_deque_unit: top level of the bounded deque, a row of bdq_cell slots
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_cell
//
// response: registered, valid in the cycle after the request transfer
// throughput: one request per cycle unless a held response stalls; the row shifts
// reset: arst_n clears the occupancy and all cell valid bits; slot data is not reset

module bounded_deque_unit (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);

	localparam int unsigned DEPTH  = bdq_pkg::DEPTH;
	localparam int unsigned DATA_W = bdq_pkg::DATA_W;
	localparam int unsigned CNT_W  = bdq_pkg::CNT_W;

	// cell row: index 0 is the front, occupied cells form a run from the front
	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0]         cell_valid;

	bdq_pkg::bdq_ctl_t        ctl;
	logic                     accept;
	logic                     full;
	logic                     empty;
	logic [1:0]               status_d;
	logic signed [DATA_W-1:0] pop_value_d;
	logic signed [DATA_W-1:0] tail_word;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;

	// response register
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] pop_value_q;
	logic [1:0]               status_q;
	logic [CNT_W-1:0]         occupancy_q;

	// take a new request whenever the response register is free or being drained
	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = req.valid & req.ready;

	assign full  = cell_valid[DEPTH-1];
	assign empty = ~cell_valid[0];

	// the tail cell is unique, so an or over the row picks its word
	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_word = tail_word | cell_tail[i];
		end
	end

	// decode the request against full/empty; dropped requests leave the row alone
	always_comb begin
		ctl         = '0;
		status_d    = bdq_pkg::ST_OK;
		pop_value_d = '0;
		unique case (req.func)
			bdq_pkg::FUNC_PUSH_FRONT: begin
				if (full) status_d = bdq_pkg::ST_FULL;
				else ctl.push_front = accept;
			end
			bdq_pkg::FUNC_PUSH_REAR: begin
				if (full) status_d = bdq_pkg::ST_FULL;
				else ctl.push_rear = accept;
			end
			bdq_pkg::FUNC_POP_FRONT: begin
				if (empty) begin
					status_d = bdq_pkg::ST_EMPTY;
				end else begin
					ctl.pop_front = accept;
					pop_value_d   = cell_data[0];
				end
			end
			bdq_pkg::FUNC_POP_REAR: begin
				if (empty) begin
					status_d = bdq_pkg::ST_EMPTY;
				end else begin
					ctl.pop_rear = accept;
					pop_value_d  = tail_word;
				end
			end
			default: begin
				status_d = bdq_pkg::ST_OK;
			end
		endcase
	end

	// occupancy after this request
	always_comb begin
		count_d = count_q;
		if (ctl.push_front || ctl.push_rear) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.pop_front || ctl.pop_rear) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// row of cells; the front cell sees the pushed word as its left neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_data;
		logic                     left_valid;
		logic signed [DATA_W-1:0] right_data;
		logic                     right_valid;

		if (i == 0) begin : g_front
			assign left_data  = req.push_value;
			assign left_valid = 1'b1;
		end else begin : g_inner_l
			assign left_data  = cell_data[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign right_data  = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner_r
			assign right_data  = cell_data[i+1];
			assign right_valid = cell_valid[i+1];
		end

		bdq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.push_value  (req.push_value),
			.left_data   (left_data),
			.left_valid  (left_valid),
			.right_data  (right_data),
			.right_valid (right_valid),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.tail_data   (cell_tail[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, loaded on each request transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			pop_value_q <= pop_value_d;
			status_q    <= status_d;
			occupancy_q <= count_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = pop_value_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occupancy_q;

`ifndef SYNTHESIS
	// count register tracks the number of occupied cells
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == count_q)
		else $error("occupancy count disagrees with cell valid bits");

	// occupied cells always form one run starting at the front
	a_run_from_front: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + {{(DEPTH-1){1'b0}}, 1'b1}) & cell_valid) == '0)
		else $error("cell valid bits are not a run from the front");

	// a full report only happens when every cell is occupied
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == bdq_pkg::ST_FULL) |-> occupancy_q == CNT_W'(DEPTH))
		else $error("full status with free cells");

	// a pop on an empty row reports empty with a zero word
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func[1] && count_q == '0) |=>
		(rsp_valid_q && status_q == bdq_pkg::ST_EMPTY && pop_value_q == '0))
		else $error("pop on empty deque not reported as empty");
`endif

endmodule
